FILE: src/cad_pkg.sv
package cad_pkg;

  localparam int DATA_W  = 32;
  localparam int IDX_W   = 8;
  localparam int CNT_O_W = 9;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_DELETE = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

endpackage

FILE: src/cad_ram.sv
module cad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/compacting_array_range_delete_top.sv
// Results: push, pop, write and any rejected operation register their result in the
//   cycle after the transaction; a read registers the RAM word, then the result.
// Throughput: one push/pop/write per cycle while the result side is not stalled; a read
//   or a range delete holds off new transactions until its result is registered.
// Reset (rst, synchronous): fill count and control clear at once; the entry
//   RAM is not cleared, no clearing pass is needed.
module compacting_array_range_delete_top
  import cad_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                opcode,
  input  logic [IDX_W-1:0]          index,
  input  logic [IDX_W-1:0]          end_index,
  input  logic signed [DATA_W-1:0]  value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  read_value,
  output logic [CNT_O_W-1:0]        fill_count,
  output logic [1:0]                status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // compare width: holds both the 8-bit indexes and the count
  localparam int XW = (CW > IDX_W + 1) ? CW : IDX_W + 1;
  localparam logic [CW-1:0] CNT_ONE = 1;
  localparam logic [XW-1:0] X_ONE   = 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_MOVE} state_t;

  state_t        state;
  logic [CW-1:0] count;     // entries held
  logic [CW-1:0] src;       // next entry to move down
  logic [AW-1:0] dst;       // where it goes
  logic [CW-1:0] move_end;  // count before the delete
  logic          pend;      // read issued last cycle, write it back now
  logic [AW-1:0] pend_dst;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic    accept;
  opcode_t op;
  logic    full;
  logic    empty;
  logic    idx_ok;
  logic    range_ok;
  logic    more;
  logic [CW-1:0] del_count;

  // Only one transaction is in flight; the next one waits until the result
  // register is free (or drains in this same cycle).
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign op       = opcode_t'(opcode);

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign idx_ok   = XW'(index) < XW'(count);
  assign range_ok = (index <= end_index) && (XW'(end_index) < XW'(count));
  assign del_count = CW'(XW'(count) - (XW'(end_index) - XW'(index) + X_ONE));
  assign more     = src < move_end;

  // RAM port steering. Compaction reads src and writes the word read in the
  // cycle before to dst; dst always trails src, so no entry is read after
  // it has been overwritten.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(count);
    ram_wdata = value;
    ram_re    = 1'b0;
    ram_raddr = AW'(index);
    if (state == S_MOVE) begin
      ram_we    = pend;
      ram_waddr = pend_dst;
      ram_wdata = ram_rdata;
      ram_re    = more;
      ram_raddr = AW'(src);
    end else if (accept) begin
      unique case (op)
        OP_PUSH:  ram_we = !full;
        OP_WRITE: begin
          ram_we    = idx_ok;
          ram_waddr = AW'(index);
        end
        OP_READ:  ram_re = idx_ok;
        default:  ram_we = 1'b0;
      endcase
    end
  end

  cad_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            read_value <= '0;
            fill_count <= CNT_O_W'(count);
            status     <= ST_OK;
            out_valid  <= 1'b1;
            unique case (op)
              OP_PUSH: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  count      <= count + CNT_ONE;
                  fill_count <= CNT_O_W'(count + CNT_ONE);
                end
              end
              OP_POP: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  count      <= count - CNT_ONE;
                  fill_count <= CNT_O_W'(count - CNT_ONE);
                end
              end
              OP_READ: begin
                if (!idx_ok) begin
                  status <= ST_BAD;
                end else begin
                  // result waits for the RAM read
                  out_valid <= 1'b0;
                  state     <= S_READ;
                end
              end
              OP_WRITE: begin
                if (!idx_ok) begin
                  status <= ST_BAD;
                end
              end
              OP_DELETE: begin
                if (!range_ok) begin
                  status <= ST_BAD;
                end else begin
                  out_valid <= 1'b0;
                  count     <= del_count;
                  move_end  <= count;
                  src       <= CW'(XW'(end_index) + X_ONE);
                  dst       <= AW'(index);
                  pend      <= 1'b0;
                  state     <= S_MOVE;
                end
              end
              default: status <= ST_OK;
            endcase
          end
        end
        S_READ: begin
          read_value <= ram_rdata;
          fill_count <= CNT_O_W'(count);
          status     <= ST_OK;
          out_valid  <= 1'b1;
          state      <= S_IDLE;
        end
        S_MOVE: begin
          pend     <= more;
          pend_dst <= dst;
          if (more) begin
            src <= src + CNT_ONE;
            dst <= dst + AW'(1);
          end else if (!pend) begin
            // all moved words written back
            read_value <= '0;
            fill_count <= CNT_O_W'(count);
            status     <= ST_OK;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/cad_checker.sv
module cad_checker
  import cad_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] read_value,
  input logic [CNT_O_W-1:0]       fill_count,
  input logic [1:0]               status
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_value)
      && $stable(fill_count) && $stable(status))
    else $error("stalled result changed");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> read_value == '0)
    else $error("failed operation returned data");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> fill_count == CNT_O_W'(DEPTH))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> fill_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind compacting_array_range_delete_top cad_checker #(.DEPTH(DEPTH)) u_cad_checker (.*);

FILE: bench/compacting_array_range_delete_top_tb.sv
module compacting_array_range_delete_top_tb;
  import cad_pkg::*;

  localparam int ARRAY_DEPTH = 256;
  // opcodes with no operation behind them; the block must leave the array alone
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  // one result transaction as the block should present it
  typedef struct {
    logic signed [DATA_W-1:0] rd;
    logic [CNT_O_W-1:0]       cnt;
    status_t                  st;
  } result_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [2:0]               opcode;
  logic [IDX_W-1:0]         index;
  logic [IDX_W-1:0]         end_index;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] read_value;
  logic [CNT_O_W-1:0]       fill_count;
  logic [1:0]               status;

  // shadow copy of the array: contents and fill count
  logic [DATA_W-1:0]  shadow_words [ARRAY_DEPTH];
  logic [CNT_O_W-1:0] held_count;

  result_t pending_results[$];
  int      error_count;
  int      sent_count;
  int      checked_count;
  int      status_tally [4];
  int      moved_words;
  // while set, neither side idles
  bit      steady;

  compacting_array_range_delete_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .index      (index),
    .end_index  (end_index),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .fill_count (fill_count),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog. It leaves ample margin over the slowest legal run, even with
  // every range delete walking most of the array.
  initial begin
    #(20_000_000);
    $display("compacting_array_range_delete_top test failed");
    $finish;
  end

  // Result side backpressure: roughly one cycle in four held off.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 24);
  end

  // Predict the result of one accepted transaction and update the shadow array.
  // Range delete shifts everything above end_index down, preserving order.
  function automatic result_t apply_op(logic [2:0] op, logic [IDX_W-1:0] first,
                                       logic [IDX_W-1:0] last, logic [DATA_W-1:0] word);
    result_t r;
    int      src;
    int      dst;
    r.rd = '0;
    r.st = ST_OK;
    case (op)
      OP_PUSH: begin
        if (int'(held_count) >= ARRAY_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          shadow_words[held_count] = word;
          held_count = held_count + 1'b1;
        end
      end
      OP_POP: begin
        if (held_count == 0) r.st = ST_EMPTY;
        else held_count = held_count - 1'b1;
      end
      OP_READ: begin
        if (int'(first) >= int'(held_count)) r.st = ST_BAD;
        else r.rd = shadow_words[first];
      end
      OP_WRITE: begin
        if (int'(first) >= int'(held_count)) r.st = ST_BAD;
        else shadow_words[first] = word;
      end
      OP_DELETE: begin
        if (first > last || int'(last) >= int'(held_count)) begin
          r.st = ST_BAD;
        end else begin
          src = int'(last) + 1;
          dst = int'(first);
          while (src < int'(held_count)) begin
            shadow_words[dst] = shadow_words[src];
            dst++;
            src++;
            moved_words++;
          end
          held_count = held_count - CNT_O_W'(int'(last) - int'(first) + 1);
        end
      end
      default: ;
    endcase
    r.cnt = held_count;
    return r;
  endfunction

  // Send one transaction. in_valid is left high on return so a following
  // call can go back to back; the next call (or a drain) decides to lower it.
  // Unless steady is set, each cycle before the transaction idles with a one-in-four chance.
  task automatic send_op(input logic [2:0] op, input logic [IDX_W-1:0] first,
                         input logic [IDX_W-1:0] last, input logic [DATA_W-1:0] word);
    result_t want;
    while (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    index     <= first;
    end_index <= last;
    value     <= word;
    do @(posedge clk); while (!in_ready);
    want = apply_op(op, first, last, word);
    pending_results = {pending_results, want};
    status_tally[int'(want.st)]++;
    sent_count++;
  endtask

  // Hold the input side off until every outstanding result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Empty-array corners, extreme data words, unused opcodes, every bad-index
  // and bad-range flavor, and a middle delete that has to shift entries.
  task automatic test_directed_corners();
    send_op(OP_POP, 8'd0, 8'd0, '0);
    send_op(OP_READ, 8'd0, 8'd0, '0);
    send_op(OP_WRITE, 8'd0, 8'd0, 32'h1234_5678);
    send_op(OP_DELETE, 8'd0, 8'd0, '0);
    for (int op = int'(OP_UNUSED_FIRST); op <= int'(OP_UNUSED_LAST); op++) begin
      send_op(3'(op), 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    end
    send_op(OP_PUSH, 8'd0, 8'd0, 32'h8000_0000);
    send_op(OP_PUSH, 8'd0, 8'd0, 32'h7FFF_FFFF);
    send_op(OP_PUSH, 8'd0, 8'd0, 32'h0000_0000);
    send_op(OP_PUSH, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 8'd0, 8'd0, 32'h5555_5555);
    send_op(OP_READ, 8'd0, 8'd0, '0);
    send_op(OP_READ, 8'd4, 8'd0, '0);
    send_op(OP_READ, 8'd5, 8'd0, '0);      // first index past the end
    send_op(OP_READ, 8'hFF, 8'd0, '0);
    send_op(OP_WRITE, 8'd1, 8'd0, 32'hAAAA_AAAA);
    send_op(OP_WRITE, 8'd5, 8'd0, 32'h0F0F_0F0F);
    send_op(OP_DELETE, 8'd3, 8'd1, '0);    // reversed range
    send_op(OP_DELETE, 8'd2, 8'd5, '0);    // end past the fill count
    send_op(OP_DELETE, 8'd1, 8'd2, '0);    // shifts two entries down
    send_op(OP_READ, 8'd1, 8'd0, '0);
    send_op(OP_UNUSED_FIRST, 8'd0, 8'd0, '0);
    send_op(OP_DELETE, 8'd0, 8'd0, '0);
    wait_drained();
  endtask

  // Fill to capacity back to back (no idling on either side), then exercise
  // the top index, the full flag and the longest possible shift.
  task automatic test_full_array();
    steady = 1'b1;
    while (int'(held_count) < ARRAY_DEPTH) send_op(OP_PUSH, 8'd0, 8'd0, $urandom());
    send_op(OP_PUSH, 8'd0, 8'd0, 32'hDEAD_BEEF);
    send_op(OP_READ, 8'hFF, 8'd0, '0);
    send_op(OP_WRITE, 8'hFF, 8'd0, 32'h8000_0001);
    send_op(OP_READ, 8'hFF, 8'd0, '0);
    send_op(OP_DELETE, 8'hFF, 8'hFF, '0);  // last entry, nothing to move
    send_op(OP_PUSH, 8'd0, 8'd0, 32'h7FFF_FFFE);
    send_op(OP_DELETE, 8'd0, 8'd0, '0);    // moves all 255 others
    steady = 1'b0;
    send_op(OP_READ, 8'd0, 8'd0, '0);
    send_op(OP_READ, 8'd254, 8'd0, '0);
    send_op(OP_DELETE, 8'd0, 8'hFF, '0);   // past the end by one
    send_op(OP_DELETE, 8'd10, 8'd200, '0);
    send_op(OP_READ, 8'd10, 8'd0, '0);
    wait_drained();
  endtask

  // Mostly well-formed traffic at a fill level kept away from both ends,
  // with a slice of fully random fields and broken ranges mixed in.
  task automatic test_random_mix(input int n_ops);
    int         pick;
    int         push_w;
    int         first;
    int         last;
    int         span;
    int         room;
    logic [2:0] op;
    repeat (n_ops) begin
      pick   = $urandom_range(99);
      first  = $urandom_range(255);
      last   = $urandom_range(255);
      push_w = (held_count < 32) ? 35 : (held_count > 224) ? 20 : 30;
      if (pick < 5) op = 3'($urandom_range(7));
      else if (pick < 5 + push_w) op = OP_PUSH;
      else if (pick < 15 + push_w) op = OP_POP;
      else if (pick < 40 + push_w) op = OP_READ;
      else if (pick < 55 + push_w) op = OP_WRITE;
      else op = OP_DELETE;

      if (pick >= 5 && held_count > 0) begin
        if ((op == OP_READ || op == OP_WRITE) && $urandom_range(99) < 85) begin
          first = $urandom_range(int'(held_count) - 1);
        end else if (op == OP_DELETE) begin
          if ($urandom_range(99) < 80) begin
            first = $urandom_range(int'(held_count) - 1);
            room  = int'(held_count) - first;
            span  = ($urandom_range(9) == 0) ? $urandom_range(1, room)
                                             : $urandom_range(1, (room < 4) ? room : 4);
            last  = first + span - 1;
          end else if ($urandom_range(1) == 0 && first < last) begin
            span  = first;
            first = last;
            last  = span;
          end
        end
      end
      send_op(op, IDX_W'(first), IDX_W'(last), $urandom());
    end
    wait_drained();
  endtask

  // Clear everything with one range delete, then bounce off empty.
  task automatic test_drain_to_empty();
    send_op(OP_PUSH, 8'd0, 8'd0, $urandom());
    send_op(OP_DELETE, 8'd0, IDX_W'(int'(held_count) - 1), '0);
    send_op(OP_POP, 8'd0, 8'd0, '0);
    send_op(OP_READ, 8'd0, 8'd0, '0);
    send_op(OP_PUSH, 8'd0, 8'd0, 32'h0000_0001);
    send_op(OP_POP, 8'd0, 8'd0, '0);
    send_op(OP_POP, 8'd0, 8'd0, '0);
    wait_drained();
  endtask

  // Result checker: every accepted result must match the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction pending: read_value %0d fill_count %0d status %0d",
                 $time, read_value, fill_count, status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (read_value !== want.rd) begin
          $display("%0t: read_value mismatch, expected %0d, actual %0d",
                   $time, want.rd, read_value);
          error_count++;
        end
        if (fill_count !== want.cnt) begin
          $display("%0t: fill_count mismatch, expected %0d, actual %0d",
                   $time, want.cnt, fill_count);
          error_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.st, status);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    opcode     = OP_PUSH;
    index      = '0;
    end_index  = '0;
    value      = '0;
    held_count = '0;
    steady     = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_full_array();
    test_random_mix(1550);
    test_drain_to_empty();

    // wait past the longest range delete; anything arriving late
    // shows up here as an unexpected result
    repeat (300) @(posedge clk);

    $display("Ran %0d transactions, %0d results checked, %0d entries shifted by range deletes.",
             sent_count, checked_count, moved_words);
    $display("Status seen: ok %0d, full %0d, empty %0d, bad index/range %0d.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("compacting_array_range_delete_top test passed");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      $display("compacting_array_range_delete_top test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/cad_pkg.sv
src/cad_ram.sv
src/compacting_array_range_delete_top.sv
src/cad_checker.sv
bench/compacting_array_range_delete_top_tb.sv
